// ----- rtl/imu_rol_pkg.sv -----
// Shared types, constants and helpers for the IMU remap, offset and low-pass block.
`default_nettype none

package imu_rol_pkg;

  // Sample and filter state formats
  localparam int SmpW    = 16;          // sensor samples, offsets and results
  localparam int StW     = 32;          // filter state, Q17.15
  localparam int CoefW   = 32;          // feedback coefficients, Q2.30
  localparam int CoefBW  = 23;          // feed-forward coefficient fits in 23 bits
  localparam int BxW     = CoefBW + SmpW;
  localparam int AccW    = 64;
  localparam int FracW   = 15;          // Q17.15 fraction bits
  localparam int CoefFrW = 30;          // Q2.30 fraction bits
  localparam int NumAxes = 3;
  localparam int CfgIdxW = 3;

  typedef logic signed [SmpW-1:0] smp_t;
  typedef logic signed [StW-1:0]  st_t;
  typedef logic signed [BxW-1:0]  bx_t;

  // Filter coefficients: A1 + A2 + B = 2^30
  localparam logic signed [CoefW-1:0]  COEF_A1 = 32'sd2071735500;
  localparam logic signed [CoefW-1:0]  COEF_A2 = -32'sd1000494913;
  localparam logic signed [CoefBW-1:0] COEF_B  = 23'sd2501237;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_GYRO_BIAS_X  = 3'd0,
    REG_GYRO_BIAS_Y  = 3'd1,
    REG_GYRO_BIAS_Z  = 3'd2,
    REG_ACCEL_BIAS_X = 3'd3,
    REG_ACCEL_BIAS_Y = 3'd4,
    REG_ACCEL_BIAS_Z = 3'd5
  } reg_idx_t;

  // Pipeline load strobes from the top-level flow control
  typedef struct packed {
    logic cal_load;
    logic lpf_load;
  } pipe_ctl_t;

  // Clamp an 18-bit signed value to the signed 16-bit range
  function automatic smp_t sat16(input logic signed [SmpW+1:0] v);
    smp_t r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SmpW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/imu_rol_cal.sv -----
// Offset registers, board-frame axis remap, offset add and filter input product.
`default_nettype none

module imu_rol_cal (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [imu_rol_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [imu_rol_pkg::SmpW-1:0]        cfg_wdata,
  input  wire imu_rol_pkg::pipe_ctl_t              ctl,
  input  wire imu_rol_pkg::smp_t                   gyro_raw  [imu_rol_pkg::NumAxes],
  input  wire imu_rol_pkg::smp_t                   accel_raw [imu_rol_pkg::NumAxes],
  output imu_rol_pkg::smp_t                        rate      [imu_rol_pkg::NumAxes],
  output imu_rol_pkg::smp_t                        acc_cal   [imu_rol_pkg::NumAxes],
  output imu_rol_pkg::bx_t                         bx        [imu_rol_pkg::NumAxes]
);

  imu_rol_pkg::smp_t gyro_bias_r  [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t accel_bias_r [imu_rol_pkg::NumAxes];

  imu_rol_pkg::smp_t rate_r [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t cal_r  [imu_rol_pkg::NumAxes];
  imu_rol_pkg::bx_t  bx_r   [imu_rol_pkg::NumAxes];

  imu_rol_pkg::smp_t g_brd [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t a_brd [imu_rol_pkg::NumAxes];
  logic              g_neg;   // board y comes from negated sensor x
  imu_rol_pkg::smp_t rate_nxt [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t cal_nxt  [imu_rol_pkg::NumAxes];
  imu_rol_pkg::bx_t  bx_nxt   [imu_rol_pkg::NumAxes];

  // Offset register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
        gyro_bias_r[i]  <= '0;
        accel_bias_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (imu_rol_pkg::reg_idx_t'(cfg_index))
        imu_rol_pkg::REG_GYRO_BIAS_X:  gyro_bias_r[0]  <= cfg_wdata;
        imu_rol_pkg::REG_GYRO_BIAS_Y:  gyro_bias_r[1]  <= cfg_wdata;
        imu_rol_pkg::REG_GYRO_BIAS_Z:  gyro_bias_r[2]  <= cfg_wdata;
        imu_rol_pkg::REG_ACCEL_BIAS_X: accel_bias_r[0] <= cfg_wdata;
        imu_rol_pkg::REG_ACCEL_BIAS_Y: accel_bias_r[1] <= cfg_wdata;
        imu_rol_pkg::REG_ACCEL_BIAS_Z: accel_bias_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mounting matrix: board x = sensor y, board y = -sensor x, board z = sensor z
  assign g_brd[0] = gyro_raw[1];
  assign g_brd[1] = gyro_raw[0];
  assign g_brd[2] = gyro_raw[2];
  assign a_brd[0] = accel_raw[1];
  assign a_brd[1] = accel_raw[0];
  assign a_brd[2] = accel_raw[2];

  // Offset add at 17 bits (negation of -32768 stays exact), then clamp
  always_comb begin
    logic signed [imu_rol_pkg::SmpW:0] gs;
    logic signed [imu_rol_pkg::SmpW:0] as;
    logic signed [imu_rol_pkg::SmpW:0] ge;
    logic signed [imu_rol_pkg::SmpW:0] ae;
    g_neg = 1'b0;
    for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
      g_neg = (i == 1);
      ge = {g_brd[i][imu_rol_pkg::SmpW-1], g_brd[i]};
      ae = {a_brd[i][imu_rol_pkg::SmpW-1], a_brd[i]};
      if (g_neg) begin
        ge = -ge;
        ae = -ae;
      end
      gs = ge + {gyro_bias_r[i][imu_rol_pkg::SmpW-1], gyro_bias_r[i]};
      as = ae + {accel_bias_r[i][imu_rol_pkg::SmpW-1], accel_bias_r[i]};
      rate_nxt[i] = imu_rol_pkg::sat16({gs[imu_rol_pkg::SmpW], gs});
      cal_nxt[i]  = imu_rol_pkg::sat16({as[imu_rol_pkg::SmpW], as});
    end
  end

  // Feed-forward term B * x, before the Q17.15 shift
  always_comb begin
    for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
      bx_nxt[i] = imu_rol_pkg::COEF_B * cal_nxt[i];
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (ctl.cal_load) begin
      for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
        rate_r[i] <= rate_nxt[i];
        cal_r[i]  <= cal_nxt[i];
        bx_r[i]   <= bx_nxt[i];
      end
    end
  end

  assign rate    = rate_r;
  assign acc_cal = cal_r;
  assign bx      = bx_r;

endmodule

`default_nettype wire

// ----- rtl/imu_rol_lpf.sv -----
// Per-axis second-order low-pass filter state and result register.
`default_nettype none

module imu_rol_lpf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire imu_rol_pkg::pipe_ctl_t ctl,
  input  wire imu_rol_pkg::smp_t     rate_in   [imu_rol_pkg::NumAxes],
  input  wire imu_rol_pkg::smp_t     cal_in    [imu_rol_pkg::NumAxes],
  input  wire imu_rol_pkg::bx_t      bx_in     [imu_rol_pkg::NumAxes],
  output imu_rol_pkg::smp_t          rate      [imu_rol_pkg::NumAxes],
  output imu_rol_pkg::smp_t          acc_cal   [imu_rol_pkg::NumAxes],
  output imu_rol_pkg::smp_t          acc_smooth[imu_rol_pkg::NumAxes]
);

  localparam int QW = imu_rol_pkg::AccW - imu_rol_pkg::CoefFrW;   // quotient width
  localparam int BxPad = imu_rol_pkg::AccW - imu_rol_pkg::BxW - imu_rol_pkg::FracW;
  localparam logic signed [imu_rol_pkg::AccW-1:0] RndHalf =
    64'sd1 <<< (imu_rol_pkg::CoefFrW - 1);

  imu_rol_pkg::st_t  hist_newest_r [imu_rol_pkg::NumAxes];
  imu_rol_pkg::st_t  hist_older_r  [imu_rol_pkg::NumAxes];
  logic              primed_r;
  imu_rol_pkg::smp_t rate_r   [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t cal_r    [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t smooth_r [imu_rol_pkg::NumAxes];

  imu_rol_pkg::st_t  hist_newest_nxt [imu_rol_pkg::NumAxes];
  imu_rol_pkg::st_t  hist_older_nxt  [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t smooth_nxt      [imu_rol_pkg::NumAxes];

  // Recursion y = A1*y1 + A2*y2 + B*x, rounded and clamped to 32 bits;
  // the first beat after reset loads both history stages with x
  always_comb begin
    logic signed [imu_rol_pkg::AccW-1:0] p1;
    logic signed [imu_rol_pkg::AccW-1:0] p2;
    logic signed [imu_rol_pkg::AccW-1:0] bxe;
    logic signed [imu_rol_pkg::AccW-1:0] acc;
    logic signed [QW-1:0]                q;
    imu_rol_pkg::st_t                    y_new;
    imu_rol_pkg::st_t                    x;
    logic signed [imu_rol_pkg::StW:0]    rs;
    for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
      p1  = imu_rol_pkg::COEF_A1 * hist_newest_r[i];
      p2  = imu_rol_pkg::COEF_A2 * hist_older_r[i];
      bxe = {{BxPad{bx_in[i][imu_rol_pkg::BxW-1]}}, bx_in[i], {imu_rol_pkg::FracW{1'b0}}};
      acc = p1 + p2 + bxe + RndHalf;
      q   = acc[imu_rol_pkg::AccW-1:imu_rol_pkg::CoefFrW];
      if (q[QW-1:imu_rol_pkg::StW-1] == '0 || q[QW-1:imu_rol_pkg::StW-1] == '1) begin
        y_new = q[imu_rol_pkg::StW-1:0];
      end else if (q[QW-1]) begin
        y_new = {1'b1, {(imu_rol_pkg::StW-1){1'b0}}};
      end else begin
        y_new = {1'b0, {(imu_rol_pkg::StW-1){1'b1}}};
      end
      x = {cal_in[i][imu_rol_pkg::SmpW-1], cal_in[i], {imu_rol_pkg::FracW{1'b0}}};
      if (!primed_r) begin
        hist_newest_nxt[i] = x;
        hist_older_nxt[i]  = x;
      end else begin
        hist_newest_nxt[i] = y_new;
        hist_older_nxt[i]  = hist_newest_r[i];
      end
      // Round half up to an integer and clamp
      rs = {hist_newest_nxt[i][imu_rol_pkg::StW-1], hist_newest_nxt[i]}
           + 33'sd16384;
      smooth_nxt[i] = imu_rol_pkg::sat16(rs[imu_rol_pkg::StW:imu_rol_pkg::FracW]);
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
        hist_newest_r[i] <= '0;
        hist_older_r[i]  <= '0;
      end
    end else if (ctl.lpf_load) begin
      primed_r <= 1'b1;
      for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
        hist_newest_r[i] <= hist_newest_nxt[i];
        hist_older_r[i]  <= hist_older_nxt[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.lpf_load) begin
      for (int i = 0; i < imu_rol_pkg::NumAxes; i++) begin
        rate_r[i]   <= rate_in[i];
        cal_r[i]    <= cal_in[i];
        smooth_r[i] <= smooth_nxt[i];
      end
    end
  end

  assign rate       = rate_r;
  assign acc_cal    = cal_r;
  assign acc_smooth = smooth_r;

endmodule

`default_nettype wire

// ----- rtl/imu_axis_remap_offset_lowpass_unit.sv -----
// Top level: input register, pipeline flow control, calibration and filter stages.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one six-axis sensor-frame beat:
//   three gyro and three accelerometer samples. The result channel
//   (out_valid / out_stall) returns one beat per input beat with the board-frame
//   rates, the offset-corrected accelerations and the low-passed accelerations.
//   The user sets offsets through cfg_we / cfg_index / cfg_wdata while the
//   block is idle (unchecked by the block); writes to unused indexes are dropped.
// Timing:
//   Three register stages (input, calibration, filter/result); a beat moves
//   through them in that order. One beat per cycle is sustained while
//   out_stall is low; the filter feedback closes through the state registers,
//   so back-to-back beats never wait on each other.
// Reset:
//   rst_n (synchronous, active low) clears the offsets to zero, the filter
//   history to zero and marks the filter unprimed: the next beat loads both
//   history stages with its own acceleration.
// Stall:
//   While out_stall is high the result holds; the earlier stages keep taking
//   beats until they are full, then in_stall rises.
`default_nettype none

module imu_axis_remap_offset_lowpass_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [imu_rol_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [imu_rol_pkg::SmpW-1:0]    cfg_wdata,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire imu_rol_pkg::smp_t               in_gyro_raw_x,
  input  wire imu_rol_pkg::smp_t               in_gyro_raw_y,
  input  wire imu_rol_pkg::smp_t               in_gyro_raw_z,
  input  wire imu_rol_pkg::smp_t               in_accel_raw_x,
  input  wire imu_rol_pkg::smp_t               in_accel_raw_y,
  input  wire imu_rol_pkg::smp_t               in_accel_raw_z,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output imu_rol_pkg::smp_t                    out_rate_x,
  output imu_rol_pkg::smp_t                    out_rate_y,
  output imu_rol_pkg::smp_t                    out_rate_z,
  output imu_rol_pkg::smp_t                    out_acc_cal_x,
  output imu_rol_pkg::smp_t                    out_acc_cal_y,
  output imu_rol_pkg::smp_t                    out_acc_cal_z,
  output imu_rol_pkg::smp_t                    out_acc_smooth_x,
  output imu_rol_pkg::smp_t                    out_acc_smooth_y,
  output imu_rol_pkg::smp_t                    out_acc_smooth_z
);

  logic in_v_r, cal_v_r, out_v_r;
  logic in_rdy, cal_rdy, out_rdy;
  logic in_load;
  imu_rol_pkg::pipe_ctl_t ctl;

  imu_rol_pkg::smp_t gyro_r  [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t accel_r [imu_rol_pkg::NumAxes];

  imu_rol_pkg::smp_t s_rate [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t s_cal  [imu_rol_pkg::NumAxes];
  imu_rol_pkg::bx_t  s_bx   [imu_rol_pkg::NumAxes];

  imu_rol_pkg::smp_t o_rate   [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t o_cal    [imu_rol_pkg::NumAxes];
  imu_rol_pkg::smp_t o_smooth [imu_rol_pkg::NumAxes];

  // Flow control: a stage takes a beat when empty or when it drains this cycle
  assign out_rdy = !out_v_r || !out_stall;
  assign cal_rdy = !cal_v_r || out_rdy;
  assign in_rdy  = !in_v_r  || cal_rdy;
  assign in_stall = !in_rdy;
  assign in_load  = in_valid && in_rdy;
  assign ctl.cal_load = in_v_r && cal_rdy;
  assign ctl.lpf_load = cal_v_r && out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      cal_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_rdy)  in_v_r  <= in_valid;
      if (cal_rdy) cal_v_r <= in_v_r;
      if (out_rdy) out_v_r <= cal_v_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_load) begin
      gyro_r[0]  <= in_gyro_raw_x;
      gyro_r[1]  <= in_gyro_raw_y;
      gyro_r[2]  <= in_gyro_raw_z;
      accel_r[0] <= in_accel_raw_x;
      accel_r[1] <= in_accel_raw_y;
      accel_r[2] <= in_accel_raw_z;
    end
  end

  imu_rol_cal u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .gyro_raw  (gyro_r),
    .accel_raw (accel_r),
    .rate      (s_rate),
    .acc_cal   (s_cal),
    .bx        (s_bx)
  );

  imu_rol_lpf u_lpf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rate_in    (s_rate),
    .cal_in     (s_cal),
    .bx_in      (s_bx),
    .rate       (o_rate),
    .acc_cal    (o_cal),
    .acc_smooth (o_smooth)
  );

  assign out_valid        = out_v_r;
  assign out_rate_x       = o_rate[0];
  assign out_rate_y       = o_rate[1];
  assign out_rate_z       = o_rate[2];
  assign out_acc_cal_x    = o_cal[0];
  assign out_acc_cal_y    = o_cal[1];
  assign out_acc_cal_z    = o_cal[2];
  assign out_acc_smooth_x = o_smooth[0];
  assign out_acc_smooth_y = o_smooth[1];
  assign out_acc_smooth_z = o_smooth[2];

endmodule

`default_nettype wire
